// File: rtl/core/md5_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and index helpers for the MD5 digest engine.
// No dependencies; used by md5_round and md5_message_digest.
package md5_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_abcd;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] PAD_WORD   = 32'h0000_0080;
    localparam logic [3:0]  LEN_LO_POS = 4'd14;
    localparam logic [3:0]  LAST_POS   = 4'd15;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [1:0]  LAST_IDX   = 2'd3;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    localparam logic [1:0] PH_F = 2'd0;
    localparam logic [1:0] PH_G = 2'd1;
    localparam logic [1:0] PH_H = 2'd2;
    localparam logic [1:0] PH_I = 2'd3;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] S_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a round, modulo 16.
    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        unique case (rnd[5:4])
            PH_F:    idx = r4;
            PH_G:    idx = (r4 << 2) + r4 + 4'd1;
            PH_H:    idx = (r4 << 1) + r4 + 4'd5;
            PH_I:    idx = (r4 << 3) - r4;
            default: idx = r4;
        endcase
        return idx;
    endfunction

endpackage

// File: rtl/core/md5_round.sv
`timescale 1ns / 1ps
// One MD5 round step: logic function, four-way add, rotate and final add.
// Depends on md5_pkg for the constant tables and the t_abcd type.
module md5_round import md5_pkg::*; (
    input  t_abcd       i_cur,
    input  logic [31:0] i_msg,
    input  logic [5:0]  i_rnd,
    output t_abcd       o_nxt
);

    logic [31:0] f;
    logic [31:0] t;
    logic [4:0]  amt;
    logic [63:0] dbl;

    always_comb begin
        unique case (i_rnd[5:4])
            PH_F:    f = (i_cur.b & i_cur.c) | (~i_cur.b & i_cur.d);
            PH_G:    f = (i_cur.d & i_cur.b) | (~i_cur.d & i_cur.c);
            PH_H:    f = i_cur.b ^ i_cur.c ^ i_cur.d;
            PH_I:    f = i_cur.c ^ (i_cur.b | ~i_cur.d);
            default: f = '0;
        endcase
    end

    assign t   = f + i_cur.a + K_TAB[i_rnd] + i_msg;
    assign amt = S_TAB[{i_rnd[5:4], i_rnd[1:0]}];
    // rotate left: shift a doubled copy and keep the upper half
    assign dbl = {t, t} << amt;

    assign o_nxt.a = i_cur.d;
    assign o_nxt.d = i_cur.c;
    assign o_nxt.c = i_cur.b;
    assign o_nxt.b = i_cur.b + dbl[63:32];

endmodule

// File: rtl/core/md5_message_digest.sv
`timescale 1ns / 1ps
// MD5 digest engine top level: word gathering, padding sequencer, round loop.
// Depends on md5_pkg and md5_round.
//
// Usage:
//   Input stream (s_axis_*): one message word per beat, byte 0 in bits 7:0.
//   tuser carries the valid byte count (0..4, larger values taken as 4) and
//   tlast marks the final word; only the final word may be partial.
//   Output stream (m_axis_*): four beats per message, digest words A, B, C, D;
//   tuser gives the word index and tlast flags word D.
// Flow:
//   A word that does not complete a 16-word block is stored and the engine
//   waits for the next one. The sixteenth word starts the compression: 64
//   rounds through the single shared round unit, then a fold into the
//   chaining value; no word is accepted until the block is done. On the last
//   word the padding sequencer writes one pad or length word per cycle, runs
//   one or two compressions, then offers the digest.
//   s_axis_tready is high only while the engine waits for a word.
// Reset:
//   i_rst_n (synchronous, active low) returns the chaining value to the MD5
//   initial values and clears the length, word count and sequencer.
// Stall:
//   The digest is held on m_axis_tdata until each beat is taken; no new
//   message word is accepted until word D has gone.
module md5_message_digest import md5_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // digest_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RUN,
        ST_ADD,
        ST_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_buf [16];
    logic [3:0]  r_wcnt;
    logic [63:0] r_len;
    logic [31:0] r_cv [4];
    t_abcd       r_ab;
    logic [5:0]  r_rnd;
    logic [1:0]  r_oidx;
    logic        r_padding;   // message ended, padding in progress
    logic        r_pad_pend;  // pad byte still owed as a word of its own
    logic        r_lo_done;   // low length word written
    logic        r_fin;       // high length word written: last block queued

    logic        in_acc;
    logic        out_acc;
    logic [2:0]  cnt;
    logic [31:0] in_word;
    logic        n_push;
    logic [31:0] n_word;
    t_abcd       rnd_nxt;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_cv[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == LAST_IDX);

    // saturate the byte count; on a last word keep the valid bytes, drop the rest
    // and place the pad byte straight after them
    assign cnt = (s_axis_tuser > FULL_BYTES) ? FULL_BYTES : s_axis_tuser;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (!s_axis_tlast || (3'(i) < cnt)) begin
                in_word[8*i +: 8] = s_axis_tdata[8*i +: 8];
            end else if (3'(i) == cnt) begin
                in_word[8*i +: 8] = PAD_WORD[7:0];
            end else begin
                in_word[8*i +: 8] = 8'h00;
            end
        end
    end

    // word written into the block buffer this cycle
    always_comb begin
        n_push = 1'b0;
        n_word = in_word;
        unique case (r_state)
            ST_IDLE: begin
                n_push = in_acc;
                n_word = in_word;
            end
            ST_PAD: begin
                n_push = 1'b1;
                priority if (r_pad_pend) begin
                    n_word = PAD_WORD;
                end else if (r_wcnt == LEN_LO_POS) begin
                    n_word = r_len[31:0];
                end else if (r_lo_done) begin
                    n_word = r_len[63:32];
                end else begin
                    n_word = '0;
                end
            end
            default: begin
                n_push = 1'b0;
                n_word = in_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_buf[r_wcnt] <= n_word;
        end
    end

    md5_round u_round (
        .i_cur (r_ab),
        .i_msg (r_buf[msg_idx(r_rnd)]),
        .i_rnd (r_rnd),
        .o_nxt (rnd_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wcnt     <= '0;
            r_len      <= '0;
            r_cv[0]    <= IV_A;
            r_cv[1]    <= IV_B;
            r_cv[2]    <= IV_C;
            r_cv[3]    <= IV_D;
            r_ab       <= '0;
            r_rnd      <= '0;
            r_oidx     <= '0;
            r_padding  <= 1'b0;
            r_pad_pend <= 1'b0;
            r_lo_done  <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            if (n_push) begin
                r_wcnt <= r_wcnt + 4'd1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_len <= r_len + (s_axis_tlast ? 64'({cnt, 3'b000}) : 64'd32);
                        if (s_axis_tlast) begin
                            r_padding  <= 1'b1;
                            r_pad_pend <= (cnt == FULL_BYTES);
                        end
                        if (r_wcnt == LAST_POS) begin
                            r_ab    <= '{a: r_cv[0], b: r_cv[1], c: r_cv[2], d: r_cv[3]};
                            r_rnd   <= '0;
                            r_state <= ST_RUN;
                        end else if (s_axis_tlast) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_pend <= 1'b0;
                    if (!r_pad_pend && r_wcnt == LEN_LO_POS) begin
                        r_lo_done <= 1'b1;
                    end else if (!r_pad_pend && r_lo_done) begin
                        r_fin <= 1'b1;
                    end
                    if (r_wcnt == LAST_POS) begin
                        r_ab    <= '{a: r_cv[0], b: r_cv[1], c: r_cv[2], d: r_cv[3]};
                        r_rnd   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_ab <= rnd_nxt;
                    if (r_rnd == LAST_ROUND) begin
                        r_rnd   <= '0;
                        r_state <= ST_ADD;
                    end else begin
                        r_rnd <= r_rnd + 6'd1;
                    end
                end
                ST_ADD: begin
                    r_cv[0] <= r_cv[0] + r_ab.a;
                    r_cv[1] <= r_cv[1] + r_ab.b;
                    r_cv[2] <= r_cv[2] + r_ab.c;
                    r_cv[3] <= r_cv[3] + r_ab.d;
                    priority if (r_fin) begin
                        r_oidx  <= '0;
                        r_state <= ST_OUT;
                    end else if (r_padding) begin
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == LAST_IDX) begin
                            // message done: back to the initial chaining value
                            r_cv[0]   <= IV_A;
                            r_cv[1]   <= IV_B;
                            r_cv[2]   <= IV_C;
                            r_cv[3]   <= IV_D;
                            r_len     <= '0;
                            r_padding <= 1'b0;
                            r_lo_done <= 1'b0;
                            r_fin     <= 1'b0;
                            r_state   <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest offered");

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tlast) |=> !s_axis_tready)
        else $error("word accepted straight after a last word");

    a_digest_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("digest stream broken before word D");

    a_rnd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rnd != 6'd0) |-> (r_state == ST_RUN))
        else $error("round counter live outside the round loop");

endmodule

// File: tb/tb_md5_message_digest.sv
`timescale 1ns / 1ps
// Self-checking testbench for md5_message_digest: drives message words as stream beats,
// predicts every digest beat with its own MD5 model and checks the output stream.
// Depends on md5_pkg and the md5_message_digest RTL only.
module tb_md5_message_digest;
    import md5_pkg::*;

    localparam int WORD_TARGET = 350;   // queue at least this many message words in all
    localparam int CALM_TAIL   = 40;    // no new idle bursts once this few words remain
    localparam int HOLD_AT     = 120;   // words taken before the long output hold
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 150;  // longer than two compressions

    // Per-round additive constants and rotation amounts of the MD5 rounds.
    localparam bit [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    localparam bit [31:0] START_HASH [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };
    localparam bit [31:0] PAD_BYTE = 32'h0000_0080;
    localparam bit [2:0]  WHOLE_WORD = 3'd4;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } msg_word_t;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] data_word
    logic [2:0]  s_axis_tuser = '0;     // [2:0] byte_count
    logic        s_axis_tlast = 1'b0;   // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] digest_word
    logic [1:0]  m_axis_tuser;          // [1:0] word_index
    logic        m_axis_tlast;          // digest_last

    md5_message_digest dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    msg_word_t    word_q[$];      // words waiting to be offered
    digest_beat_t digest_q[$];    // digest beats the engine still owes
    msg_word_t    next_word;

    // Predicted engine state.
    bit [31:0]   hash_state [4];
    bit [31:0]   blk_words [16];
    int unsigned blk_fill;
    bit [63:0]   msg_bits;

    int unsigned mismatches = 0;
    int unsigned words_taken = 0;
    bit          word_taken = 1'b0;   // set on an input handshake, cleared by the driver
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic bit [31:0] rol32(input bit [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One 64-round compression of the gathered block into the hash state.
    function automatic void compress_block();
        bit [31:0] a, b, c, d, f, t;
        int g;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = 5 * r + 1;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = 3 * r + 5;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = 7 * r;
                end
            endcase
            t = f + a + SINE_K[r] + blk_words[g % 16];
            a = d;
            d = c;
            c = b;
            b = b + rol32(t, ROT_AMT[(r / 16) * 4 + r % 4]);
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
    endfunction

    function automatic void gather_word(input bit [31:0] w);
        blk_words[blk_fill] = w;
        blk_fill++;
        if (blk_fill == 16) begin
            compress_block();
            blk_fill = 0;
        end
    endfunction

    function automatic void restart_hash();
        for (int k = 0; k < 4; k++) hash_state[k] = START_HASH[k];
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    // Fold one accepted word into the prediction; a last word pads, appends
    // the bit length and yields the four digest beats.
    function automatic void predict_word(input msg_word_t mw);
        bit [2:0]  cnt;
        bit [31:0] mask;
        digest_beat_t db;
        cnt = (mw.count > WHOLE_WORD) ? WHOLE_WORD : mw.count;
        if (!mw.last) begin
            msg_bits += 64'd32;
            gather_word(mw.data);
            return;
        end
        msg_bits += 64'(cnt) * 64'd8;
        if (cnt == WHOLE_WORD) begin
            gather_word(mw.data);
            gather_word(PAD_BYTE);
        end else begin
            mask = (cnt == 3'd0) ? 32'd0 : (32'hffff_ffff >> (32 - 8 * cnt));
            gather_word((mw.data & mask) | (PAD_BYTE << (8 * cnt)));
        end
        while (blk_fill != 14) gather_word(32'd0);
        gather_word(msg_bits[31:0]);
        gather_word(msg_bits[63:32]);
        for (int k = 0; k < 4; k++) begin
            db.word = hash_state[k];
            db.idx  = 2'(k);
            db.last = (k == 3);
            digest_q.push_back(db);
        end
        restart_hash();
    endfunction

    function automatic void queue_word(input bit [31:0] d, input bit [2:0] c, input bit l);
        msg_word_t mw;
        mw.data  = d;
        mw.count = c;
        mw.last  = l;
        word_q.push_back(mw);
    endfunction

    // Sender: offer words from the queue, hold each until taken, idle in bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !word_taken) begin
            // hold the beat until the engine takes it
        end else begin
            word_taken = 1'b0;
            if (in_gap != 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (word_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (word_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                in_gap = $urandom_range(0, 16);
                s_axis_tvalid <= 1'b0;
            end else begin
                next_word = word_q.pop_front();
                s_axis_tdata  <= next_word.data;
                s_axis_tuser  <= next_word.count;
                s_axis_tlast  <= next_word.last;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: ready in bursts, and low throughout the long hold.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (out_gap != 0) begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end else if (word_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
            out_gap = $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Long output hold: start once partway through, count it down here, so the
    // engine sits on a digest and has to refuse the words still being offered.
    always @(posedge i_clk) begin
        if (!hold_done && words_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: predict on every input beat, check every output beat.
    always @(posedge i_clk) begin
        msg_word_t    seen;
        digest_beat_t want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen.data  = s_axis_tdata;
            seen.count = s_axis_tuser;
            seen.last  = s_axis_tlast;
            predict_word(seen);
            word_taken = 1'b1;
            words_taken <= words_taken + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected digest beat %h idx %0d",
                                        m_axis_tdata, m_axis_tuser));
            end else begin
                want = digest_q.pop_front();
                if (m_axis_tdata !== want.word)
                    flag_mismatch($sformatf("digest word %0d: got %h, want %h",
                                            want.idx, m_axis_tdata, want.word));
                if (m_axis_tuser !== want.idx)
                    flag_mismatch($sformatf("word index: got %0d, want %0d",
                                            m_axis_tuser, want.idx));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("digest last on word %0d: got %b, want %b",
                                            want.idx, m_axis_tlast, want.last));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int len;
        restart_hash();

        // Directed: every byte count on a lone last word, all-zero and
        // all-one data, over-range counts, ignored counts on inner words.
        queue_word(32'hffff_ffff, 3'd0, 1'b1);
        queue_word(32'hffff_ffff, 3'd1, 1'b1);
        queue_word(32'h0000_0000, 3'd2, 1'b1);
        queue_word(32'hffff_ffff, 3'd3, 1'b1);
        queue_word(32'hffff_ffff, 3'd4, 1'b1);
        queue_word(32'ha5a5_a5a5, 3'd7, 1'b1);
        queue_word(32'h0000_0000, 3'd0, 1'b0);
        queue_word(32'hffff_ffff, 3'd5, 1'b0);
        queue_word(32'h5a5a_5a5a, 3'd6, 1'b1);
        // Thirteen whole words and a partial one: the length just fits.
        for (int k = 0; k < 13; k++) queue_word(32'h0101_0101 * k, WHOLE_WORD, 1'b0);
        queue_word(32'hdead_beef, 3'd3, 1'b1);

        // Random messages, mostly short, some spanning two or three blocks.
        while (word_q.size() < WORD_TARGET) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(0, 16);
            for (int k = 0; k < len; k++)
                queue_word($urandom, ($urandom_range(0, 15) == 0) ?
                           3'($urandom_range(0, 7)) : WHOLE_WORD, 1'b0);
            queue_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || s_axis_tvalid || digest_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[md5_message_digest] OK");
        end else begin
            $display("[md5_message_digest] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[md5_message_digest] ERROR");
        $finish;
    end

endmodule
